// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the checksum verifier RTL. Each macro is
// clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/l4cv_pkg.sv -----
// ----------------------------------------------------------------------------
// l4cv_pkg
// Types and constants of the L4 checksum verifier: item layout, command
// and protocol codes, and fixed header lengths.
// ----------------------------------------------------------------------------
package l4cv_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_ADDR   = 2'd1,
        CMD_BYTE   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Network layer codes
    localparam logic [1:0] L3_IPV4  = 2'd0;
    localparam logic [1:0] L3_IPV6  = 2'd1;
    localparam logic [1:0] L3_OTHER = 2'd2;

    // Transport layer codes
    localparam logic [2:0] L4_TCP   = 3'd0;
    localparam logic [2:0] L4_UDP   = 3'd1;
    localparam logic [2:0] L4_ICMP  = 3'd2;
    localparam logic [2:0] L4_ICMP6 = 3'd3;
    localparam logic [2:0] L4_OTHER = 3'd4;

    // Fixed lengths and positions
    localparam logic [17:0] IPV6_HDR_LEN    = 18'd40;
    localparam logic [4:0]  IPV4_ADDR_WORDS = 5'd4;
    localparam logic [4:0]  IPV6_ADDR_WORDS = 5'd16;
    localparam logic [17:0] UDP_HDR_LEN     = 18'd8;
    localparam logic [15:0] UDP_CSUM_HI     = 16'd6;
    localparam logic [15:0] UDP_CSUM_LO     = 16'd7;

    // Port widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;

    // One input item, unpacked
    typedef struct packed {
        cmd_t        cmd;
        logic [1:0]  l3_kind;
        logic [2:0]  l4_kind;
        logic [7:0]  protocol;
        logic        fragmented;
        logic [15:0] l3_length;
        logic [5:0]  header_length;
        logic [15:0] l3_offset;
        logic [15:0] l4_offset;
        logic [15:0] captured_length;
        logic [15:0] value;
    } item_t;

    // One result item
    typedef struct packed {
        logic checked;
        logic checksum_ok;
    } result_t;

endpackage

// ----- hdl/l4cv_core.sv -----
// ----------------------------------------------------------------------------
// l4cv_core
// Per-packet checksum state and the update for one item, worked out
// combinationally and committed on go: header qualification, address and
// pseudo-header sum, byte accumulation and the final fold and compare.
// ----------------------------------------------------------------------------
module l4cv_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  l4cv_pkg::item_t   item,      // item held in the input register
    input  logic              go,        // commit this item's state update
    output logic              emit,      // the item produces a result
    output l4cv_pkg::result_t result
);

    logic [31:0] sum_reg,        sum_next;
    logic [15:0] seg_len_reg,    seg_len_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  held_reg,       held_next;
    logic [4:0]  addr_cnt_reg,   addr_cnt_next;
    logic        active_reg,     active_next;
    logic        pseudo_reg,     pseudo_next;
    logic        ipv6_reg,       ipv6_next;
    logic        udp_reg,        udp_next;
    logic        udp_zero_reg,   udp_zero_next;

    // Header qualification
    logic        is_ipv4;
    logic        is_ipv6;
    logic        is_udp;
    logic        hdr_pseudo;
    logic [17:0] l3_end;
    logic [17:0] l4_off_w;
    logic [17:0] seg_wide;
    logic [15:0] cap_room;
    logic        hdr_skip;

    // Byte path
    logic [7:0]  byte_val;
    logic [15:0] idx_next;
    logic        byte_last;
    logic [31:0] byte_add;
    logic [31:0] byte_sum;
    logic        byte_udp_zero;
    logic [4:0]  addr_expect;

    // End-around carry fold; true when the complemented sum is zero
    function automatic logic fold_ok(input logic [31:0] s);
        logic [16:0] t1;
        logic [15:0] t2;
        begin
            t1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
            t2 = t1[15:0] + {15'd0, t1[16]};
            fold_ok = (t2 == 16'hFFFF);
        end
    endfunction

    // Work out segment length and whether the packet is checked at all
    always_comb begin
        is_ipv4    = (item.l3_kind == l4cv_pkg::L3_IPV4);
        is_ipv6    = (item.l3_kind == l4cv_pkg::L3_IPV6);
        is_udp     = (item.l4_kind == l4cv_pkg::L4_UDP);
        hdr_pseudo = (item.l4_kind == l4cv_pkg::L4_TCP) || is_udp ||
                     (item.l4_kind == l4cv_pkg::L4_ICMP6);
        l4_off_w   = {2'b00, item.l4_offset};
        l3_end     = {2'b00, item.l3_offset} + {2'b00, item.l3_length} +
                     (is_ipv6 ? l4cv_pkg::IPV6_HDR_LEN : 18'd0);
        seg_wide   = l3_end - l4_off_w;
        cap_room   = item.captured_length - item.l4_offset;
        hdr_skip   = (item.l4_kind > l4cv_pkg::L4_ICMP6) ||
                     !(is_ipv4 || is_ipv6) ||
                     (is_ipv4 && (item.fragmented ||
                                  (item.l3_length < {10'd0, item.header_length}))) ||
                     (l3_end <= l4_off_w) ||
                     (item.l4_offset > item.captured_length) ||
                     (seg_wide > {2'b00, cap_room}) ||
                     (is_udp && (seg_wide < l4cv_pkg::UDP_HDR_LEN));
    end

    // Accumulate one segment byte and detect the end of the segment
    always_comb begin
        byte_val      = item.value[7:0];
        idx_next      = bytes_seen_reg + 16'd1;
        byte_last     = (idx_next >= seg_len_reg);
        if (bytes_seen_reg[0]) begin
            byte_add = {16'd0, held_reg, byte_val};
        end else if (byte_last) begin
            byte_add = {16'd0, byte_val, 8'h00};
        end else begin
            byte_add = 32'd0;
        end
        byte_sum      = sum_reg + byte_add;
        byte_udp_zero = udp_zero_reg &&
                        !(((bytes_seen_reg == l4cv_pkg::UDP_CSUM_HI) ||
                           (bytes_seen_reg == l4cv_pkg::UDP_CSUM_LO)) &&
                          (byte_val != 8'h00));
        addr_expect   = ipv6_reg ? l4cv_pkg::IPV6_ADDR_WORDS : l4cv_pkg::IPV4_ADDR_WORDS;
    end

    // Next state and result for the held item
    always_comb begin
        sum_next        = sum_reg;
        seg_len_next    = seg_len_reg;
        bytes_seen_next = bytes_seen_reg;
        held_next       = held_reg;
        addr_cnt_next   = addr_cnt_reg;
        active_next     = active_reg;
        pseudo_next     = pseudo_reg;
        ipv6_next       = ipv6_reg;
        udp_next        = udp_reg;
        udp_zero_next   = udp_zero_reg;
        emit            = 1'b0;
        result          = '0;
        case (item.cmd)
            l4cv_pkg::CMD_HEADER: begin
                active_next = !hdr_skip;
                emit        = hdr_skip;
                if (!hdr_skip) begin
                    sum_next        = hdr_pseudo ?
                                      ({24'd0, item.protocol} + {16'd0, seg_wide[15:0]}) :
                                      32'd0;
                    seg_len_next    = seg_wide[15:0];
                    bytes_seen_next = 16'd0;
                    held_next       = 8'h00;
                    addr_cnt_next   = 5'd0;
                    pseudo_next     = hdr_pseudo;
                    ipv6_next       = is_ipv6;
                    udp_next        = is_udp;
                    udp_zero_next   = 1'b1;
                end
            end
            l4cv_pkg::CMD_ADDR: begin
                if (active_reg && pseudo_reg && (addr_cnt_reg < addr_expect)) begin
                    sum_next      = sum_reg + {16'd0, item.value};
                    addr_cnt_next = addr_cnt_reg + 5'd1;
                end
            end
            l4cv_pkg::CMD_BYTE: begin
                if (active_reg) begin
                    sum_next        = byte_sum;
                    udp_zero_next   = byte_udp_zero;
                    bytes_seen_next = idx_next;
                    if (!bytes_seen_reg[0]) begin
                        held_next = byte_val;
                    end
                    if (byte_last) begin
                        active_next        = 1'b0;
                        emit               = 1'b1;
                        result.checked     = !(udp_reg && byte_udp_zero);
                        result.checksum_ok = !(udp_reg && byte_udp_zero) &&
                                             fold_ok(byte_sum);
                    end
                end
            end
            default: begin
                // hold everything
            end
        endcase
    end

    // Packet state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= 32'd0;
            seg_len_reg    <= 16'd0;
            bytes_seen_reg <= 16'd0;
            held_reg       <= 8'h00;
            addr_cnt_reg   <= 5'd0;
            active_reg     <= 1'b0;
            pseudo_reg     <= 1'b0;
            ipv6_reg       <= 1'b0;
            udp_reg        <= 1'b0;
            udp_zero_reg   <= 1'b1;
        end else if (go) begin
            sum_reg        <= sum_next;
            seg_len_reg    <= seg_len_next;
            bytes_seen_reg <= bytes_seen_next;
            held_reg       <= held_next;
            addr_cnt_reg   <= addr_cnt_next;
            active_reg     <= active_next;
            pseudo_reg     <= pseudo_next;
            ipv6_reg       <= ipv6_next;
            udp_reg        <= udp_next;
            udp_zero_reg   <= udp_zero_next;
        end
    end

endmodule

// ----- hdl/l4_checksum_verifier_top.sv -----
// ----------------------------------------------------------------------------
// l4_checksum_verifier_top
// Streaming verifier of TCP, UDP, ICMP and ICMPv6 checksums (with the
// pseudo-header, except for ICMP), fed by header, address-word and segment-byte items.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one item per handshake. s_tuser gives the item kind
//   (header facts, address word, segment byte); s_tdata carries the fields.
//   A header either yields an unchecked result at once or arms the block;
//   address words and segment bytes then add into the running sum, and the
//   byte that completes the segment yields the result.
//   Master channel m_*: m_tuser is the checked flag, m_tdata bit 0 says the
//   checksum is good.
// Timing:
//   One item per cycle sustained, unless the held item's result must wait for
//   one not yet taken. An item sits in the input register, where the sum update
//   and final fold are done, and its result goes to the result register that drives m_tvalid.
// Reset and stall:
//   aresetn clears the valid flags of both registers and leaves the block
//   idle with no packet armed. While m_tready is low a waiting result holds;
//   items that produce no result still flow, and s_tready drops only when the
//   held item needs the occupied result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l4_checksum_verifier_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // l3_kind, l4_kind, protocol, fragmented, l3_length, header_length,
    // l3_offset, l4_offset, captured_length, value; zero pad to 104
    input  logic [l4cv_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // checksum_ok; zero pad to 8
    output logic [l4cv_pkg::M_TDATA_W-1:0] m_tdata,
    // checked
    output logic                           m_tuser
);

    l4cv_pkg::item_t   in_item;
    l4cv_pkg::item_t   in_reg;
    logic              in_vld_reg,  in_vld_next;
    logic              out_vld_reg, out_vld_next;
    l4cv_pkg::result_t out_reg,     out_next;
    logic              go;
    logic              core_emit;
    l4cv_pkg::result_t core_result;

    // Unpack the slave item
    always_comb begin
        in_item.cmd             = l4cv_pkg::cmd_t'(s_tuser);
        in_item.l3_kind         = s_tdata[1:0];
        in_item.l4_kind         = s_tdata[4:2];
        in_item.protocol        = s_tdata[12:5];
        in_item.fragmented      = s_tdata[13];
        in_item.l3_length       = s_tdata[29:14];
        in_item.header_length   = s_tdata[35:30];
        in_item.l3_offset       = s_tdata[51:36];
        in_item.l4_offset       = s_tdata[67:52];
        in_item.captured_length = s_tdata[83:68];
        in_item.value           = s_tdata[99:84];
    end

    // Advance the held item unless its result would overwrite one not taken
    assign go       = in_vld_reg && (!core_emit || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || go;

    l4cv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_reg),
        .go      (go),
        .emit    (core_emit),
        .result  (core_result)
    );

    // Input and result register control
    always_comb begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (s_tready) begin
            in_vld_next = s_tvalid;
        end
        if (go && core_emit) begin
            out_vld_next = 1'b1;
            out_next     = core_result;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_item;
        end
        out_reg <= out_next;
    end

    // Drive the master item
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.checked;
    assign m_tdata  = {{(l4cv_pkg::M_TDATA_W-1){1'b0}}, out_reg.checksum_ok};

    `ASSERT_CLK(a_ok_implies_checked, m_tvalid |-> (m_tuser || !m_tdata[0]), "good checksum on an unchecked result")
    `ASSERT_NEVER(a_result_overwrite, go && core_emit && out_vld_reg && !m_tready, "result register overwritten before it was taken")
    `ASSERT_CLK(a_stall_needs_item, !s_tready |-> (in_vld_reg && core_emit && out_vld_reg), "input stalled without a blocked result")

endmodule

// ----- tb/tb_l4_checksum_verifier_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_l4_checksum_verifier_top
// Self-checking bench for the L4 checksum verifier. Header, address-word and
// segment-byte items are streamed in as whole packets with random content
// (mostly well formed, some corrupted, cut short or padded with stray items).
// A scoreboard class tracks the running sum and packet state of the block and
// compares every verdict on the master channel against its own prediction.
// ----------------------------------------------------------------------------
module tb_l4_checksum_verifier_top;

    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int BIG_ROOM     = 700;

    // Protocol numbers carried in the header
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    typedef enum int {
        FLAW_NONE,
        FLAW_CORRUPT,
        FLAW_FEW_ADDR,
        FLAW_MORE_ADDR,
        FLAW_MIXED,
        FLAW_CUT,
        FLAW_TAIL
    } flaw_t;

    // Prediction of checksum verdicts and comparison with the block
    class csum_scoreboard;
        logic [31:0] sum_acc;
        logic [16:0] seg_len;
        logic [16:0] byte_cnt;
        logic [7:0]  hi_byte;
        logic [4:0]  addr_cnt;
        bit          armed;
        bit          pseudo;
        bit          v6;
        bit          udp;
        bit          udp_zero;
        l4cv_pkg::result_t verdict_q[$];
        int          items_in;
        int          verdicts;
        int          verified;
        int          good;
        int          errors;

        function new();
            sum_acc  = '0;
            seg_len  = '0;
            byte_cnt = '0;
            hi_byte  = '0;
            addr_cnt = '0;
            armed    = 1'b0;
            pseudo   = 1'b0;
            v6       = 1'b0;
            udp      = 1'b0;
            udp_zero = 1'b1;
            items_in = 0;
            verdicts = 0;
            verified = 0;
            good     = 0;
            errors   = 0;
        endfunction

        function void push_verdict(bit chk, bit ok);
            l4cv_pkg::result_t v;
            v.checked     = chk;
            v.checksum_ok = ok;
            verdict_q.push_back(v);
        endfunction

        // Fold with end-around carry and test the complement for zero
        function bit sum_is_good(logic [31:0] s);
            s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
            s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
            return (~s[15:0]) == 16'h0;
        endfunction

        // Advance the predicted state by one accepted item
        function void note_item(l4cv_pkg::item_t it);
            logic [17:0] l3_end;
            logic [17:0] seg;
            logic [4:0]  addr_max;
            logic [7:0]  b;
            logic [16:0] idx;
            bit          skip;
            items_in++;
            case (it.cmd)
                l4cv_pkg::CMD_HEADER: begin
                    armed  = 1'b0;
                    skip   = 1'b0;
                    l3_end = '0;
                    if (it.l4_kind > l4cv_pkg::L4_ICMP6) begin
                        skip = 1'b1;
                    end else if (it.l3_kind == l4cv_pkg::L3_IPV4) begin
                        if (it.fragmented || it.l3_length < 16'(it.header_length))
                            skip = 1'b1;
                        l3_end = 18'(it.l3_offset) + 18'(it.l3_length);
                    end else if (it.l3_kind == l4cv_pkg::L3_IPV6) begin
                        l3_end = 18'(it.l3_offset) + l4cv_pkg::IPV6_HDR_LEN +
                                 18'(it.l3_length);
                    end else begin
                        skip = 1'b1;
                    end
                    seg = l3_end - 18'(it.l4_offset);
                    if (!skip && (l3_end <= 18'(it.l4_offset) ||
                                  it.l4_offset > it.captured_length ||
                                  seg > 18'(it.captured_length) - 18'(it.l4_offset)))
                        skip = 1'b1;
                    if (!skip && it.l4_kind == l4cv_pkg::L4_UDP &&
                        seg < l4cv_pkg::UDP_HDR_LEN)
                        skip = 1'b1;
                    if (skip) begin
                        push_verdict(1'b0, 1'b0);
                    end else begin
                        pseudo   = (it.l4_kind != l4cv_pkg::L4_ICMP);
                        sum_acc  = pseudo ? 32'(it.protocol) + 32'(seg[15:0]) : 32'd0;
                        seg_len  = seg[16:0];
                        byte_cnt = '0;
                        hi_byte  = '0;
                        addr_cnt = '0;
                        v6       = (it.l3_kind == l4cv_pkg::L3_IPV6);
                        udp      = (it.l4_kind == l4cv_pkg::L4_UDP);
                        udp_zero = 1'b1;
                        armed    = 1'b1;
                    end
                end
                l4cv_pkg::CMD_ADDR: begin
                    addr_max = v6 ? l4cv_pkg::IPV6_ADDR_WORDS : l4cv_pkg::IPV4_ADDR_WORDS;
                    if (armed && pseudo && addr_cnt < addr_max) begin
                        sum_acc  = sum_acc + 32'(it.value);
                        addr_cnt = addr_cnt + 5'd1;
                    end
                end
                l4cv_pkg::CMD_BYTE: begin
                    if (armed) begin
                        b   = it.value[7:0];
                        idx = byte_cnt;
                        if ((idx == 17'(l4cv_pkg::UDP_CSUM_HI) ||
                             idx == 17'(l4cv_pkg::UDP_CSUM_LO)) && b != 8'h0)
                            udp_zero = 1'b0;
                        if (!idx[0])
                            hi_byte = b;
                        else
                            sum_acc = sum_acc + 32'({hi_byte, b});
                        byte_cnt = idx + 17'd1;
                        // Last byte of the segment: pad an odd byte low, then decide
                        if (byte_cnt >= seg_len) begin
                            if (!idx[0])
                                sum_acc = sum_acc + 32'({b, 8'h00});
                            armed = 1'b0;
                            if (udp && udp_zero)
                                push_verdict(1'b0, 1'b0);
                            else
                                push_verdict(1'b1, sum_is_good(sum_acc));
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one result from the block with the oldest predicted verdict
        function void check_verdict(logic chk, logic ok);
            l4cv_pkg::result_t exp_v;
            if (verdict_q.size() == 0) begin
                $error("unexpected result: checked %0b, checksum_ok %0b", chk, ok);
                errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (chk !== exp_v.checked) begin
                    $error("checked: expected %0b, actual %0b", exp_v.checked, chk);
                    errors++;
                end
                if (ok !== exp_v.checksum_ok) begin
                    $error("checksum_ok: expected %0b, actual %0b", exp_v.checksum_ok, ok);
                    errors++;
                end
            end
            verdicts++;
            if (chk === 1'b1)
                verified++;
            if (ok === 1'b1)
                good++;
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [l4cv_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [l4cv_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;

    csum_scoreboard sb = new();
    int src_idle_pct;
    int sink_idle_pct;
    int cycle_count;

    l4_checksum_verifier_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one item from a falling edge and hold it until it is accepted
    task automatic push_item(input l4cv_pkg::item_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.cmd;
        s_tdata  = {4'b0, it.value, it.captured_length, it.l4_offset, it.l3_offset,
                    it.header_length, it.l3_length, it.fragmented, it.protocol,
                    it.l4_kind, it.l3_kind};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_item(it);
        @(negedge aclk);
    endtask

    // Item of a given kind; fields it does not use carry random bits
    task automatic push_simple(input l4cv_pkg::cmd_t c, input logic [15:0] v);
        logic [127:0]    r;
        l4cv_pkg::item_t it;
        r        = {$urandom, $urandom, $urandom, $urandom};
        it       = l4cv_pkg::item_t'(r[101:0]);
        it.cmd   = c;
        it.value = v;
        push_item(it);
    endtask

    function automatic l4cv_pkg::item_t make_header(
        input logic [1:0] l3k, input logic [2:0] l4k,
        input logic [7:0] proto, input logic frag,
        input logic [15:0] l3len, input logic [5:0] hlen,
        input logic [15:0] l3off, input logic [15:0] l4off,
        input logic [15:0] cap);
        l4cv_pkg::item_t h;
        h                 = '0;
        h.cmd             = l4cv_pkg::CMD_HEADER;
        h.l3_kind         = l3k;
        h.l4_kind         = l4k;
        h.protocol        = proto;
        h.fragmented      = frag;
        h.l3_length       = l3len;
        h.header_length   = hlen;
        h.l3_offset       = l3off;
        h.l4_offset       = l4off;
        h.captured_length = cap;
        h.value           = 16'hFFFF;
        return h;
    endfunction

    // One packet: header, address words and segment bytes, with an optional flaw
    task automatic send_packet(input logic [1:0] l3k, input logic [2:0] l4k,
                               input int seg_len, input flaw_t flaw);
        l4cv_pkg::item_t hdr;
        logic [7:0]  seg_b[$];
        logic [15:0] addr_w[$];
        logic [31:0] acc;
        logic [15:0] csum;
        int          n_full;
        int          n_addr;
        int          n_bytes;
        int          pos;
        int          ext;
        int          k;
        bit          pseudo_hdr;

        hdr         = '0;
        hdr.cmd     = l4cv_pkg::CMD_HEADER;
        hdr.l3_kind = l3k;
        hdr.l4_kind = l4k;
        case (l4k)
            l4cv_pkg::L4_TCP:  hdr.protocol = PROTO_TCP;
            l4cv_pkg::L4_UDP:  hdr.protocol = PROTO_UDP;
            l4cv_pkg::L4_ICMP: hdr.protocol = PROTO_ICMP;
            default:           hdr.protocol = PROTO_ICMP6;
        endcase
        if ($urandom_range(0, 9) == 0)
            hdr.protocol = 8'($urandom);
        hdr.l3_offset = 16'($urandom_range(0, 80));
        hdr.value     = 16'($urandom);
        if (l3k == l4cv_pkg::L3_IPV6) begin
            ext               = 8 * int'($urandom_range(0, 2));
            hdr.header_length = 6'($urandom);
            hdr.fragmented    = 1'($urandom);
            hdr.l3_length     = 16'(ext + seg_len);
            hdr.l4_offset     = hdr.l3_offset + 16'(40 + ext);
        end else begin
            hdr.header_length = 6'(4 * $urandom_range(5, 15));
            hdr.l3_length     = 16'(hdr.header_length) + 16'(seg_len);
            hdr.l4_offset     = hdr.l3_offset + 16'(hdr.header_length);
        end
        hdr.captured_length = hdr.l4_offset + 16'(seg_len + int'($urandom_range(0, 30)));

        pseudo_hdr = (l4k != l4cv_pkg::L4_ICMP);
        n_full = !pseudo_hdr ? 0 : (l3k == l4cv_pkg::L3_IPV6 ? 16 : 4);
        n_addr = n_full;
        if (flaw == FLAW_FEW_ADDR)
            n_addr = int'($urandom_range(0, n_full));
        if (flaw == FLAW_MORE_ADDR)
            n_addr = n_full + int'($urandom_range(1, 4));
        repeat (n_addr) addr_w.push_back(16'($urandom));
        repeat (seg_len) seg_b.push_back(8'($urandom));

        // Fill in a correct checksum where the segment holds the field, except for some UDP left at zero
        pos = (l4k == l4cv_pkg::L4_TCP) ? 16 : (l4k == l4cv_pkg::L4_UDP) ? 6 : 2;
        if (pos + 1 < seg_len) begin
            seg_b[pos]     = 8'h0;
            seg_b[pos + 1] = 8'h0;
            if (!(l4k == l4cv_pkg::L4_UDP && $urandom_range(0, 3) == 0)) begin
                acc = pseudo_hdr ? 32'(hdr.protocol) + 32'(seg_len) : 32'd0;
                for (k = 0; k < n_addr && k < n_full; k++)
                    acc = acc + 32'(addr_w[k]);
                for (k = 0; k < seg_len; k++)
                    acc = acc + (k[0] ? 32'(seg_b[k]) : 32'({seg_b[k], 8'h00}));
                acc  = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
                acc  = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
                csum = ~acc[15:0];
                seg_b[pos]     = csum[15:8];
                seg_b[pos + 1] = csum[7:0];
            end
        end
        if (flaw == FLAW_CORRUPT) begin
            k = int'($urandom_range(0, seg_len - 1));
            seg_b[k] = seg_b[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        n_bytes = (flaw == FLAW_CUT) ? int'($urandom_range(0, seg_len - 1)) : seg_len;

        push_item(hdr);
        if (flaw != FLAW_MIXED) begin
            while (addr_w.size() != 0)
                push_simple(l4cv_pkg::CMD_ADDR, addr_w.pop_front());
        end
        for (k = 0; k < n_bytes; k++) begin
            if (flaw == FLAW_MIXED) begin
                while (addr_w.size() != 0 && $urandom_range(0, 3) == 0)
                    push_simple(l4cv_pkg::CMD_ADDR, addr_w.pop_front());
                if ($urandom_range(0, 9) == 0)
                    push_simple(l4cv_pkg::CMD_NONE, 16'($urandom));
            end
            push_simple(l4cv_pkg::CMD_BYTE, {8'($urandom), seg_b[k]});
        end
        // Leftover words arrive after the packet has closed and must be ignored
        while (addr_w.size() != 0)
            push_simple(l4cv_pkg::CMD_ADDR, addr_w.pop_front());
        if (flaw == FLAW_TAIL) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1) != 0)
                    push_simple(l4cv_pkg::CMD_BYTE, 16'($urandom));
                else
                    push_simple(l4cv_pkg::CMD_ADDR, 16'($urandom));
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off once the run is under way
    initial begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held_once && sb.items_in >= 400) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Check every result taken on the master channel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_verdict(m_tuser, m_tdata[0]);
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial begin
        int    r;
        int    f;
        int    seg_len;
        flaw_t flaw;

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = l4cv_pkg::CMD_NONE;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Stray items while idle and an unused selector
        push_simple(l4cv_pkg::CMD_NONE, 16'hFFFF);
        push_simple(l4cv_pkg::CMD_BYTE, 16'hFF5A);
        push_simple(l4cv_pkg::CMD_ADDR, 16'hFFFF);
        // Headers that are skipped at once
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_TCP, 8'd0, 1'b0,
                              16'd0, 6'd0, 16'd0, 16'd0, 16'd0));
        push_item(make_header('1, '1, 8'hFF, 1'b1, 16'hFFFF, 6'h3F,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_item(make_header(l4cv_pkg::L3_OTHER, l4cv_pkg::L4_TCP, PROTO_TCP, 1'b0,
                              16'd40, 6'd20, 16'd0, 16'd20, 16'd100));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_OTHER, PROTO_TCP, 1'b0,
                              16'd40, 6'd20, 16'd0, 16'd20, 16'd100));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_TCP, PROTO_TCP, 1'b1,
                              16'd40, 6'd20, 16'd0, 16'd20, 16'd100));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_UDP, PROTO_UDP, 1'b0,
                              16'd10, 6'd20, 16'd0, 16'd20, 16'd100));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_TCP, PROTO_TCP, 1'b0,
                              16'd40, 6'd20, 16'd14, 16'd34, 16'd53));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_TCP, PROTO_TCP, 1'b0,
                              16'd200, 6'd20, 16'd0, 16'd100, 16'd50));
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_UDP, PROTO_UDP, 1'b0,
                              16'd27, 6'd20, 16'd0, 16'd20, 16'd100));
        push_item(make_header(l4cv_pkg::L3_IPV6, l4cv_pkg::L4_ICMP6, PROTO_ICMP6, 1'b0,
                              16'hFFFF, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Arm a packet, then drop it with the next header
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_TCP, PROTO_TCP, 1'b0,
                              16'd40, 6'd20, 16'd0, 16'd20, 16'd60));
        // UDP whose checksum field is zero: reported unchecked
        push_item(make_header(l4cv_pkg::L3_IPV4, l4cv_pkg::L4_UDP, PROTO_UDP, 1'b0,
                              16'd28, 6'd20, 16'd0, 16'd20, 16'd28));
        repeat (4) push_simple(l4cv_pkg::CMD_ADDR, 16'($urandom));
        repeat (8) push_simple(l4cv_pkg::CMD_BYTE, 16'hFF00);

        // Random packets with some noise; a calm stretch with no idling
        while (sb.items_in < ITEM_TARGET) begin
            if (sb.items_in >= 800 && sb.items_in < 1100) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 30;
                sink_idle_pct = 30;
            end
            r = int'($urandom_range(0, 99));
            if (r < 6) begin
                case ($urandom_range(0, 3))
                    0: push_simple(l4cv_pkg::CMD_HEADER, 16'($urandom));
                    1: push_simple(l4cv_pkg::CMD_NONE, 16'($urandom));
                    2: push_simple(l4cv_pkg::CMD_BYTE, 16'($urandom));
                    default: push_simple(l4cv_pkg::CMD_ADDR, 16'($urandom));
                endcase
            end else begin
                // Long segments only while there is room left in the item budget
                if ($urandom_range(0, 199) < 3 && sb.items_in < ITEM_TARGET - BIG_ROOM)
                    seg_len = int'($urandom_range(200, 600));
                else
                    seg_len = int'($urandom_range(1, 32));
                f = int'($urandom_range(0, 99));
                if (f < 55)      flaw = FLAW_NONE;
                else if (f < 67) flaw = FLAW_CORRUPT;
                else if (f < 74) flaw = FLAW_FEW_ADDR;
                else if (f < 81) flaw = FLAW_MORE_ADDR;
                else if (f < 90) flaw = FLAW_MIXED;
                else if (f < 95) flaw = FLAW_CUT;
                else             flaw = FLAW_TAIL;
                send_packet($urandom_range(0, 1) ? l4cv_pkg::L3_IPV6 : l4cv_pkg::L3_IPV4,
                            3'($urandom_range(0, 3)), seg_len, flaw);
            end
        end
        s_tvalid = 1'b0;

        // Drain outstanding verdicts, then allow for any late result
        while (sb.verdict_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d items and took %0d verdicts in %0d cycles.",
                 sb.items_in, sb.verdicts, cycle_count);
        $display("Of those, %0d checksums were verified and %0d found good.",
                 sb.verified, sb.good);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/l4cv_pkg.sv
hdl/l4cv_core.sv
hdl/l4_checksum_verifier_top.sv
tb/tb_l4_checksum_verifier_top.sv
